@@ src/tld_pkg.sv @@
// Shared types and constants for the tree distance engine (binary lifting).
// No dependencies; imported by the top level and the testbench.
`default_nettype none

package tld_pkg;

  // Fixed field widths of the command and result beats.
  localparam int unsigned NODE_W  = 10;
  localparam int unsigned DEPTH_W = 11;
  localparam int unsigned LEN_W   = 11;

  // Saturation limits for stored depths and reported path lengths.
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
  localparam logic [LEN_W-1:0]   LEN_MAX   = {LEN_W{1'b1}};

  typedef logic [NODE_W-1:0] node_t;

  // Command codes.
  typedef enum logic [0:0] {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_PAR,
    ST_LD_WALK,
    ST_Q_DEP,
    ST_Q_LIFT,
    ST_Q_CMP,
    ST_Q_FIN,
    ST_Q_LEN
  } state_e;

  // Command beat.
  typedef struct packed {
    action_e action;
    node_t   node_a;
    node_t   node_b;
  } in_t;

  // Result beat.
  typedef struct packed {
    node_t              lca_node;
    logic [LEN_W-1:0]   path_length;
  } out_t;

endpackage

`default_nettype wire

@@ src/tld_row_mem.sv @@
// Node row memory: one write port and two read ports with registered read data.
// Depends on nothing but its parameters; used by the top level.
`default_nettype none

module tld_row_mem #(
  parameter int unsigned WIDTH = 111,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     rd_x_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_x_i,
  output logic      [WIDTH-1:0]         rdata_x_o,
  input  wire logic                     rd_y_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_y_i,
  output logic      [WIDTH-1:0]         rdata_y_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_x_q;
  logic [WIDTH-1:0] rdata_y_q;

  // Write port; reads return the old contents on a same-cycle collision.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports hold their last data while not enabled.
  always_ff @(posedge clk_i) begin
    if (rd_x_i) begin
      rdata_x_q <= mem_q[raddr_x_i];
    end
    if (rd_y_i) begin
      rdata_y_q <= mem_q[raddr_y_i];
    end
  end

  assign rdata_x_o = rdata_x_q;
  assign rdata_y_o = rdata_y_q;

endmodule

`default_nettype wire

@@ src/tree_lca_distance_query.sv @@
// Top level of the tree distance engine: controller, row memory and result register.
// Depends on tld_pkg and tld_row_mem.
`default_nettype none

// Usage
// A command beat is taken at a rising edge where start is high and busy is low.
// A load beat (action = load) stores node_a with parent node_b: the node's depth
// and its row of 2^i-th ancestors, built from rows stored earlier. Parents must be
// loaded before children; the root takes parent 0. A load gives no result and keeps
// busy high while it builds the row, one memory read per ancestor level above level 0.
// A query beat (action = query) gives one result beat: the lowest common ancestor of
// node_a and node_b and the edge count between them. A query with equal nodes shows
// its result in the next cycle. Any other query reads both depth rows, then
// lifts the deeper node with at most one dependent row read per level, then
// lets both nodes climb together with at most one per level, and then reads
// the ancestor's row for the length. The next command is taken in the same
// cycle that the result is shown.
// Each result is marked by result_strobe_o for one cycle and stays on result_o
// until the next one; the receiver cannot stall it. After reset the block sweeps
// the row memory to zero, one row a cycle, with busy high until every row is
// cleared; then every node reads as depth 0 with all ancestors 0.
module tree_lca_distance_query
  import tld_pkg::*;
#(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned LEVELS    = 10
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  req_i,
  output logic      result_strobe_o,
  output out_t      result_o
);

  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam int unsigned LW = $clog2(LEVELS);

  // One memory word per node: its depth and its ancestor at each power of two.
  typedef struct packed {
    logic [DEPTH_W-1:0]            depth;
    logic [LEVELS-1:0][NODE_W-1:0] anc;
  } row_t;

  localparam int unsigned RW = $bits(row_t);

  // Node index to memory address.
  function automatic logic [AW-1:0] to_addr(input node_t n);
    logic [16:0] w;
    w = 17'(n);
    return w[AW-1:0];
  endfunction

  // Out-of-range node indexes map to the sentinel node.
  function automatic node_t clamp_node(input node_t n);
    return (17'(n) < 17'(MAX_NODES)) ? n : '0;
  endfunction

  state_e             state_q, state_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic [LW-1:0]      lv_q, lv_d;
  node_t              xn_q, xn_d;
  node_t              yn_q, yn_d;
  row_t               nrow_q, nrow_d;
  logic [DEPTH_W-1:0] da_q, da_d;
  logic [DEPTH_W-1:0] db_q, db_d;
  logic [LEVELS-1:0]  diff_q, diff_d;
  out_t               res_q, res_d;
  logic               strobe_q, strobe_d;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [RW-1:0]      mem_wdata;
  logic               rd_x, rd_y;
  logic [AW-1:0]      raddr_x, raddr_y;
  logic [RW-1:0]      mem_rdata_x, mem_rdata_y;
  row_t               rdx, rdy;

  logic               accept;
  node_t              a_cl, b_cl;
  logic               last_lv, zero_lv;
  logic [LW-1:0]      lv_m1;
  node_t              up_node, walk_entry;
  logic [DEPTH_W-1:0] new_depth;
  logic [15:0]        diff_w;
  logic               swap;
  node_t              lca_sel;
  logic [DEPTH_W+1:0] sum_ab, twice_l, len_w;
  logic [LEN_W-1:0]   len_clamped;

  tld_row_mem #(
    .WIDTH (RW),
    .DEPTH (MAX_NODES)
  ) u_row_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .rd_x_i    (rd_x),
    .raddr_x_i (raddr_x),
    .rdata_x_o (mem_rdata_x),
    .rd_y_i    (rd_y),
    .raddr_y_i (raddr_y),
    .rdata_y_o (mem_rdata_y)
  );

  assign rdx = row_t'(mem_rdata_x);
  assign rdy = row_t'(mem_rdata_y);

  // Command handshake and clamped node indexes.
  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign a_cl   = clamp_node(req_i.node_a);
  assign b_cl   = clamp_node(req_i.node_b);

  // Level counter decodes.
  assign last_lv = (lv_q == LW'(LEVELS - 1));
  assign zero_lv = (lv_q == '0);
  assign lv_m1   = lv_q - LW'(1);

  // Load walk: the next ancestor comes from the row of the previous one. When that
  // row is the node being loaded, its fresh entry is used instead of the old one.
  assign up_node    = nrow_q.anc[lv_m1];
  assign walk_entry = (up_node == xn_q) ? up_node : rdx.anc[lv_m1];
  assign new_depth  = (rdx.depth == DEPTH_MAX) ? DEPTH_MAX : rdx.depth + DEPTH_W'(1);

  // Query setup: the deeper node is lifted by the depth difference.
  assign swap   = (rdx.depth < rdy.depth);
  assign diff_w = swap ? (16'(rdy.depth) - 16'(rdx.depth))
                       : (16'(rdx.depth) - 16'(rdy.depth));

  // Final step: equal nodes are the answer, otherwise their common parent.
  assign lca_sel = (xn_q == yn_q) ? xn_q : rdx.anc[0];

  // Path length with clamping to the result range.
  assign sum_ab  = (DEPTH_W+2)'(da_q) + (DEPTH_W+2)'(db_q);
  assign twice_l = {1'b0, rdx.depth, 1'b0};
  assign len_w   = sum_ab - twice_l;
  always_comb begin
    if (sum_ab < twice_l) begin
      len_clamped = '0;
    end else if (len_w > (DEPTH_W+2)'(LEN_MAX)) begin
      len_clamped = LEN_MAX;
    end else begin
      len_clamped = len_w[LEN_W-1:0];
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(MAX_NODES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_i.action == ACT_LOAD) begin
            if (a_cl != '0) begin
              state_d = ST_LD_PAR;
            end
          end else if (a_cl != b_cl) begin
            state_d = ST_Q_DEP;
          end
        end
      end
      ST_LD_PAR:  state_d = ST_LD_WALK;
      ST_LD_WALK: begin
        if (last_lv) begin
          state_d = ST_IDLE;
        end
      end
      ST_Q_DEP:   state_d = ST_Q_LIFT;
      ST_Q_LIFT: begin
        if (zero_lv) begin
          state_d = ST_Q_CMP;
        end
      end
      ST_Q_CMP: begin
        if (zero_lv) begin
          state_d = ST_Q_FIN;
        end
      end
      ST_Q_FIN:   state_d = ST_Q_LEN;
      ST_Q_LEN:   state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Memory control and datapath per state.
  always_comb begin
    clr_d     = clr_q;
    lv_d      = lv_q;
    xn_d      = xn_q;
    yn_d      = yn_q;
    nrow_d    = nrow_q;
    da_d      = da_q;
    db_d      = db_q;
    diff_d    = diff_q;
    res_d     = res_q;
    strobe_d  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    rd_x      = 1'b0;
    rd_y      = 1'b0;
    raddr_x   = '0;
    raddr_y   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          xn_d = a_cl;
          yn_d = b_cl;
          if (req_i.action == ACT_LOAD) begin
            rd_x    = 1'b1;
            raddr_x = to_addr(b_cl);
          end else if (a_cl == b_cl) begin
            strobe_d          = 1'b1;
            res_d.lca_node    = a_cl;
            res_d.path_length = '0;
          end else begin
            rd_x    = 1'b1;
            rd_y    = 1'b1;
            raddr_x = to_addr(a_cl);
            raddr_y = to_addr(b_cl);
          end
        end
      end
      ST_LD_PAR: begin
        // Parent row is in; level 1 of the walk starts from it.
        nrow_d.depth  = new_depth;
        nrow_d.anc    = '0;
        nrow_d.anc[0] = yn_q;
        lv_d          = LW'(1);
      end
      ST_LD_WALK: begin
        nrow_d.anc[lv_q] = walk_entry;
        if (last_lv) begin
          mem_we    = 1'b1;
          mem_waddr = to_addr(xn_q);
          mem_wdata = nrow_d;
        end else begin
          rd_x    = 1'b1;
          raddr_x = to_addr(walk_entry);
          lv_d    = lv_q + LW'(1);
        end
      end
      ST_Q_DEP: begin
        // Keep the original depths and reread with the deeper node on port x.
        da_d   = rdx.depth;
        db_d   = rdy.depth;
        diff_d = diff_w[LEVELS-1:0];
        if (swap) begin
          xn_d = yn_q;
          yn_d = xn_q;
        end
        rd_x    = 1'b1;
        rd_y    = 1'b1;
        raddr_x = to_addr(xn_d);
        raddr_y = to_addr(yn_d);
        lv_d    = LW'(LEVELS - 1);
      end
      ST_Q_LIFT: begin
        if (diff_q[lv_q]) begin
          xn_d    = rdx.anc[lv_q];
          rd_x    = 1'b1;
          raddr_x = to_addr(xn_d);
        end
        lv_d = zero_lv ? LW'(LEVELS - 1) : lv_m1;
      end
      ST_Q_CMP: begin
        if (rdx.anc[lv_q] != rdy.anc[lv_q]) begin
          xn_d    = rdx.anc[lv_q];
          yn_d    = rdy.anc[lv_q];
          rd_x    = 1'b1;
          rd_y    = 1'b1;
          raddr_x = to_addr(xn_d);
          raddr_y = to_addr(yn_d);
        end
        lv_d = lv_m1;
      end
      ST_Q_FIN: begin
        // Fetch the ancestor's row for its depth.
        xn_d    = lca_sel;
        rd_x    = 1'b1;
        raddr_x = to_addr(lca_sel);
      end
      ST_Q_LEN: begin
        strobe_d          = 1'b1;
        res_d.lca_node    = xn_q;
        res_d.path_length = len_clamped;
      end
      default: begin
        clr_d = clr_q;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      lv_q     <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      lv_q     <= lv_d;
      strobe_q <= strobe_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    xn_q   <= xn_d;
    yn_q   <= yn_d;
    nrow_q <= nrow_d;
    da_q   <= da_d;
    db_q   <= db_d;
    diff_q <= diff_d;
    res_q  <= res_d;
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = res_q;

  // The memory is written only by the clearing sweep and at the end of a load.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_LD_WALK))
    else $error("row memory written outside a sweep or a load");

  // A result beat always coincides with the block being ready for a command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> !busy)
    else $error("result shown while busy");

  // A load never produces a result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.action == ACT_LOAD) |=> !result_strobe_o)
    else $error("result after a load");

  // A query of one node with itself answers at once with a zero length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.action == ACT_QUERY && a_cl == b_cl)
      |=> (result_strobe_o && result_o.path_length == '0))
    else $error("equal-node query not answered at once");

  // The load walk never rewrites level zero, which holds the direct parent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LD_WALK) |-> (lv_q != '0))
    else $error("load walk at level zero");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench for tree_lca_distance_query: load and query beats, predicted results.
// Depends on tld_pkg and the tree_lca_distance_query RTL; needs no files or arguments.
`timescale 1ns / 100ps

module tb;
  import tld_pkg::*;

  localparam int NODES = 1024;
  localparam int LVL   = 10;

  // Scoreboard: keeps its own copy of the depth and ancestor tables and
  // the queue of answers that queries are still owed.
  class distance_scoreboard;
    logic [DEPTH_W-1:0] depth_of [NODES];
    node_t              anc_of [NODES][LVL];
    out_t               pending_answers [$];
    int unsigned        errors;

    function new();
      foreach (depth_of[i]) depth_of[i] = '0;
      foreach (anc_of[i, j]) anc_of[i][j] = '0;
      errors = 0;
    endfunction

    // Store a node under its parent and rebuild its row of 2^i-th ancestors.
    function void store_node(int node, int par);
      int d;
      int up;
      if (node == 0) return;
      d = int'(depth_of[par]) + 1;
      if (d > int'(DEPTH_MAX)) d = int'(DEPTH_MAX);
      depth_of[node] = DEPTH_W'(d);
      anc_of[node][0] = node_t'(par);
      for (int lv = 1; lv < LVL; lv++) begin
        up = int'(anc_of[node][lv-1]);
        anc_of[node][lv] = anc_of[up][lv-1];
      end
    endfunction

    // Lift the deeper node to the other's depth, then climb both together.
    function int common_ancestor(int a, int b);
      int diff;
      int t;
      if (a == b) return a;
      if (depth_of[a] < depth_of[b]) begin
        t = a;
        a = b;
        b = t;
      end
      diff = int'(depth_of[a]) - int'(depth_of[b]);
      for (int lv = LVL - 1; lv >= 0; lv--) begin
        if (((diff >> lv) & 1) != 0) a = int'(anc_of[a][lv]);
      end
      for (int lv = LVL - 1; lv >= 0; lv--) begin
        if (anc_of[a][lv] != anc_of[b][lv]) begin
          a = int'(anc_of[a][lv]);
          b = int'(anc_of[b][lv]);
        end
      end
      if (a == b) return a;
      return int'(anc_of[a][0]);
    endfunction

    // Called for every accepted command beat.
    function void note_command(in_t cmd);
      int a;
      int b;
      int lca;
      int len;
      out_t answer;
      a = int'(cmd.node_a);
      b = int'(cmd.node_b);
      if (cmd.action == ACT_LOAD) begin
        store_node(a, b);
      end else begin
        lca = common_ancestor(a, b);
        len = int'(depth_of[a]) + int'(depth_of[b]) - 2 * int'(depth_of[lca]);
        if (len < 0) len = 0;
        if (len > int'(LEN_MAX)) len = int'(LEN_MAX);
        answer.lca_node    = node_t'(lca);
        answer.path_length = LEN_W'(len);
        pending_answers = {pending_answers, answer};
      end
    endfunction

    // Called for every result beat; compares it with the oldest owed answer.
    function void check_answer(out_t got);
      out_t want;
      if (pending_answers.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: lca %0d len %0d", got.lca_node, got.path_length);
        return;
      end
      want = pending_answers.pop_front();
      if (got.lca_node !== want.lca_node || got.path_length !== want.path_length) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected lca %0d len %0d, got lca %0d len %0d",
                   want.lca_node, want.path_length, got.lca_node, got.path_length);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t  cmd;
  logic result_strobe;
  out_t result;

  distance_scoreboard sb = new();

  int  beats_sent;
  bit  no_idle;

  tree_lca_distance_query #(
    .MAX_NODES(NODES),
    .LEVELS   (LVL)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (cmd),
    .result_strobe_o(result_strobe),
    .result_o       (result)
  );

  // 8 ns clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog against a hung block.
  initial begin
    #20ms;
    $display("FAIL tree_lca_distance_query");
    $finish;
  end

  // Result beats are sampled at the edge that ends their cycle.
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe === 1'b1) sb.check_answer(result);
  end

  // Idle length before a beat: mostly none or short, a few long.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Drive one command beat and wait until the block takes it.
  task automatic send_cmd(input action_e act, input int a, input int b);
    int gap;
    in_t beat;
    gap = pick_gap();
    beat.action = act;
    beat.node_a = node_t'(a);
    beat.node_b = node_t'(b);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd   <= beat;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_command(beat);
    beats_sent++;
    if (beats_sent % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
  endtask

  // Hold off until every owed answer has arrived and the block is idle.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending_answers.size() != 0 || busy !== 1'b0);
  endtask

  initial begin
    int loaded_q [$];
    int free_q [$];
    int chain_q [$];
    int last_node;
    int node;
    int par;
    int a;
    int b;
    int r;
    int idx;
    int s;
    int t;
    int u;

    rst_ni     = 1'b0;
    start      = 1'b0;
    cmd        = '0;
    beats_sent = 0;
    no_idle    = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: unloaded nodes, the sentinel, a small tree, ancestors,
    // equal nodes, parent loaded after child, reload and a self-parent.
    send_cmd(ACT_QUERY, 0, 0);
    send_cmd(ACT_QUERY, 1023, 0);
    send_cmd(ACT_LOAD, 0, 5);
    send_cmd(ACT_LOAD, 1, 0);
    send_cmd(ACT_LOAD, 2, 1);
    send_cmd(ACT_LOAD, 3, 1);
    send_cmd(ACT_LOAD, 1023, 2);
    send_cmd(ACT_LOAD, 4, 3);
    send_cmd(ACT_QUERY, 1023, 4);
    send_cmd(ACT_QUERY, 4, 1023);
    send_cmd(ACT_QUERY, 2, 2);
    send_cmd(ACT_QUERY, 1, 1023);
    send_cmd(ACT_QUERY, 0, 1023);
    send_cmd(ACT_QUERY, 682, 341);
    send_cmd(ACT_LOAD, 682, 1023);
    send_cmd(ACT_LOAD, 341, 682);
    send_cmd(ACT_QUERY, 341, 4);
    send_cmd(ACT_LOAD, 600, 601);
    send_cmd(ACT_LOAD, 601, 4);
    send_cmd(ACT_QUERY, 600, 4);
    send_cmd(ACT_LOAD, 2, 4);
    send_cmd(ACT_QUERY, 1023, 4);
    send_cmd(ACT_LOAD, 1023, 1023);
    send_cmd(ACT_QUERY, 1023, 1023);
    send_cmd(ACT_QUERY, 1023, 341);
    drain();

    // Random part: mostly growing well-formed trees and querying them,
    // with some reloads and raw noise.
    for (int i = 1; i < NODES; i++) free_q = {free_q, i};
    last_node = 0;
    for (int k = 0; k < 260; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        if (free_q.size() > 0) begin
          idx  = $urandom_range(0, free_q.size() - 1);
          node = free_q[idx];
          free_q.delete(idx);
          loaded_q = {loaded_q, node};
        end else begin
          node = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
        end
        r = $urandom_range(0, 99);
        if (r < 55) par = last_node;
        else if (r < 90) par = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
        else par = 0;
        send_cmd(ACT_LOAD, node, par);
        last_node = node;
      end else if (r < 85) begin
        if (loaded_q.size() == 0) begin
          a = 0;
          b = 0;
        end else begin
          a = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
          b = ($urandom_range(0, 9) == 0) ? a : loaded_q[$urandom_range(0, loaded_q.size() - 1)];
        end
        send_cmd(ACT_QUERY, a, b);
      end else if (r < 90 && loaded_q.size() > 0) begin
        node = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
        par  = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
        send_cmd(ACT_LOAD, node, par);
      end else begin
        send_cmd(action_e'($urandom_range(0, 1)), $urandom_range(0, 1023),
                 $urandom_range(0, 1023));
      end
      if (k == 130) drain();
    end
    drain();

    // One long chain so that depth differences use every lifting level.
    for (int k = 0; k < 600; k++) begin
      node = (k * 7) % 1023 + 1;
      par  = (k == 0) ? 0 : chain_q[$];
      send_cmd(ACT_LOAD, node, par);
      chain_q = {chain_q, node};
      if ($urandom_range(0, 3) == 0) begin
        a = chain_q[$urandom_range(0, chain_q.size() - 1)];
        if ($urandom_range(0, 1) == 0 || loaded_q.size() == 0)
          b = chain_q[$urandom_range(0, chain_q.size() - 1)];
        else b = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
        send_cmd(ACT_QUERY, a, b);
      end
    end
    drain();

    // Self-parent loads on the chain's tail push its depth past half the range.
    s = chain_q[$];
    for (int k = 0; k < 450; k++) begin
      send_cmd(ACT_LOAD, s, s);
      if ($urandom_range(0, 9) == 0)
        send_cmd(ACT_QUERY, s, chain_q[$urandom_range(0, chain_q.size() - 1)]);
    end

    // Two deep children, then their parent moved under the root: the
    // path length between them overflows and is clamped.
    t = chain_q[0];
    u = chain_q[1];
    send_cmd(ACT_LOAD, t, s);
    send_cmd(ACT_LOAD, u, s);
    send_cmd(ACT_LOAD, s, 0);
    send_cmd(ACT_QUERY, t, u);
    send_cmd(ACT_QUERY, t, s);
    send_cmd(ACT_QUERY, u, chain_q[5]);
    send_cmd(ACT_QUERY, s, s);
    send_cmd(ACT_LOAD, 1023, t);
    send_cmd(ACT_QUERY, 1023, u);
    send_cmd(ACT_QUERY, t, 1023);
    drain();

    // Let any stray late result show up before the verdict.
    repeat (2 * LVL + 8) @(posedge clk_i);
    if (sb.pending_answers.size() != 0) begin
      $display("%0d answers never arrived", sb.pending_answers.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASS tree_lca_distance_query");
    end else begin
      $display("FAIL tree_lca_distance_query");
    end
    $finish;
  end

endmodule
